FILE: rtl/grid_raycast_wall_columns_core_defines.svh
// Assertion macros for the port-level checker of the wall column core.
`ifndef GRID_RAYCAST_WALL_COLUMNS_CORE_DEFINES_SVH
`define GRID_RAYCAST_WALL_COLUMNS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define GRC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/grc_pkg.sv
// Shared constants, types and trigonometry table of the wall column core.
package grc_pkg;

	// Geometry and frame constants.
	localparam int NUM_RAYS      = 60;
	localparam int MAP_DIM       = 8;
	localparam int TILE_SHIFT    = 6;
	localparam int MAX_STEPS     = 8;
	localparam int SCREEN_HEIGHT = 320;

	// Fixed-point formats: positions Q.8, trigonometry Q2.14.
	localparam int QF        = 8;
	localparam int QT        = 14;
	localparam int POS_SHIFT = QF + TILE_SHIFT;
	localparam int TILE      = 1 << POS_SHIFT;
	localparam int MAP_AW    = $clog2(MAP_DIM);

	localparam int TAN_MAX   = 1048575;
	localparam int TRIG_EPS  = 16;
	localparam int MISS_DIST = 1000000 * 256;
	localparam int STEP_MAX  = 32768;
	localparam int RAW_NUM   = (1 << TILE_SHIFT) * SCREEN_HEIGHT * 256;

	// Datapath widths.
	localparam int WW     = 30;
	localparam int PW     = 47;
	localparam int DW     = 29;
	localparam int RAW_W  = $clog2(RAW_NUM + 1);
	localparam int CNT_W  = $clog2(MAX_STEPS + 1);
	localparam int RAY_W  = 6;

	typedef enum logic [1:0] {
		DIV_TAN  = 2'd0,
		DIV_RAW  = 2'd1,
		DIV_STEP = 2'd2
	} div_sel_t;

	typedef enum logic [2:0] {
		MUL_TAN   = 3'd0,
		MUL_CDX   = 3'd1,
		MUL_SDY   = 3'd2,
		MUL_CORR  = 3'd3,
		MUL_START = 3'd4
	} mul_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load_frame;
		logic     ray_init;
		logic     div_start;
		div_sel_t div_sel;
		logic     tan_cap;
		mul_sel_t mul_sel;
		logic     add_cap;
		logic     walk_en;
		logic     dist_acc;
		logic     dist_cap;
		logic     pick;
		logic     corr_cap;
		logic     raw_cap;
		logic     step_cap;
		logic     start_cap;
		logic     out_load;
		logic     next_ray;
		logic     side;
	} grc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic c_big;
		logic s_big;
		logic hit;
		logic div_done;
		logic raw_zero;
		logic out_free;
		logic last_ray;
	} grc_sts_t;

	localparam logic [14:0] SIN_TAB [0:90] = '{
		15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
		15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
		15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
		15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
		15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
		15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
		15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
		15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
		15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
		15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
		15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
		15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
		15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

	// Sine of a whole-degree angle in 0..359, Q2.14, folded into one quadrant.
	function automatic logic signed [15:0] sin_deg(input logic [8:0] a);
		logic [8:0]  tmp;
		logic        neg;
		logic signed [15:0] mag;
		tmp = a;
		neg = 1'b0;
		if (a <= 9'd90) begin
			tmp = a;
		end else if (a <= 9'd180) begin
			tmp = 9'd180 - a;
		end else if (a <= 9'd270) begin
			tmp = a - 9'd180;
			neg = 1'b1;
		end else begin
			tmp = 9'd360 - a;
			neg = 1'b1;
		end
		mag = $signed({1'b0, SIN_TAB[tmp[6:0]]});
		return neg ? -mag : mag;
	endfunction

	// Cosine as the sine of the angle advanced by a quarter turn.
	function automatic logic signed [15:0] cos_deg(input logic [8:0] a);
		logic [8:0] b;
		b = a + 9'd90;
		if (b >= 9'd360) begin
			b = b - 9'd360;
		end
		return sin_deg(b);
	endfunction

endpackage

FILE: rtl/grc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module grc_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [grc_pkg::DW-1:0] dividend,
	input  logic [grc_pkg::DW-1:0] divisor,
	output logic                   done,
	output logic [grc_pkg::DW-1:0] quotient
);
	import grc_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic          ge;

	// Trial subtraction of the divisor from the shifted partial remainder.
	assign trial = {rem_q, quo_q[DW-1]} - {1'b0, den_q};
	assign ge    = !trial[DW];

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			if (ge) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

endmodule

FILE: rtl/grc_datapath.sv
// Datapath: map store, ray walk registers, shared multiplier and divider, output register.
module grc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  grc_pkg::grc_cmd_t cmd,
	output grc_pkg::grc_sts_t sts,
	input  logic [16:0]       player_x,
	input  logic [16:0]       player_y,
	input  logic [8:0]        view_angle,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_row,
	input  logic [63:0]       cfg_data,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [71:0]       out_data,
	output logic              out_shaded,
	output logic              out_last
);
	import grc_pkg::*;

	// Frame and ray registers.
	logic [16:0]            px_q, py_q;
	logic [8:0]             ra_q;
	logic [RAY_W-1:0]       ray_q;
	logic signed [15:0]     c_q, s_q, cc_q;
	logic signed [20:0]     t_q;
	logic signed [WW-1:0]   rx_q, ry_q, xs_q, ys_q;
	logic signed [PW-1:0]   prod_q, acc_q;
	logic signed [WW-1:0]   dv_q, dh_q, d_q;
	logic [7:0]             vc_q, hc_q, code_q;
	logic [4:0]             vtex_q, htex_q, tex_q;
	logic                   shade_q;
	logic [DW-1:0]          dc_q;
	logic [RAW_W-1:0]       raw_q;
	logic [15:0]            step_q;
	logic [12:0]            start_q;
	logic [63:0]            map_q [0:7];
	logic                   valid_q;
	logic [71:0]            data_q;
	logic                   shaded_q, last_q;

	// Angles for the first ray and for the fisheye correction.
	logic [8:0]  pa_mod, ra_first, corr_ang;
	logic [9:0]  ra_sum, corr_sum;

	assign pa_mod   = (view_angle >= 9'd360) ? view_angle - 9'd360 : view_angle;
	assign ra_sum   = {1'b0, pa_mod} + 10'd30;
	assign ra_first = (ra_sum >= 10'd360) ? 9'(ra_sum - 10'd360) : ra_sum[8:0];
	assign corr_sum = 10'(ray_q) + 10'd330;
	assign corr_ang = (corr_sum >= 10'd360) ? 9'(corr_sum - 10'd360) : corr_sum[8:0];

	// Widened positions and grid line bases.
	logic signed [WW-1:0] px_w, py_w, basex, basey, tile_w, t_ext, prod_sh;
	logic signed [WW-1:0] dvx, dvy, ddx, ddy;

	assign px_w   = $signed({{(WW-17){1'b0}}, px_q});
	assign py_w   = $signed({{(WW-17){1'b0}}, py_q});
	assign basex  = $signed({{(WW-17){1'b0}}, px_q[16:POS_SHIFT], {POS_SHIFT{1'b0}}});
	assign basey  = $signed({{(WW-17){1'b0}}, py_q[16:POS_SHIFT], {POS_SHIFT{1'b0}}});
	assign tile_w = WW'(TILE);
	assign t_ext  = {{(WW-21){t_q[20]}}, t_q};
	assign prod_sh = prod_q[WW+QT-1:QT];
	assign dvx    = px_w - rx_q;
	assign dvy    = py_w - ry_q;
	assign ddx    = rx_q - px_w;
	assign ddy    = ry_q - py_w;

	// Map cell under the current walk point.
	logic [MAP_AW-1:0] mx, my;
	logic              in_map;
	logic [63:0]       map_row;
	logic [7:0]        map_cell;

	assign mx       = rx_q[POS_SHIFT+MAP_AW-1:POS_SHIFT];
	assign my       = ry_q[POS_SHIFT+MAP_AW-1:POS_SHIFT];
	assign in_map   = (rx_q[WW-1:POS_SHIFT+MAP_AW] == '0) &&
	                  (ry_q[WW-1:POS_SHIFT+MAP_AW] == '0) &&
	                  (32'(mx) < MAP_DIM) && (32'(my) < MAP_DIM);
	assign map_row  = map_q[my];
	assign map_cell = map_row[{mx, 3'b000} +: 8];

	// Shared multiplier operand selection.
	logic signed [WW-1:0] mul_a;
	logic signed [16:0]   mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MUL_TAN: begin
				mul_a = t_ext;
				mul_b = cmd.side ? dvy[16:0] : dvx[16:0];
			end
			MUL_CDX: begin
				mul_a = ddx;
				mul_b = {c_q[15], c_q};
			end
			MUL_SDY: begin
				mul_a = ddy;
				mul_b = {s_q[15], s_q};
			end
			MUL_CORR: begin
				mul_a = d_q;
				mul_b = {cc_q[15], cc_q};
			end
			MUL_START: begin
				mul_a = $signed({{(WW-RAW_W){1'b0}}, raw_q}) - WW'(SCREEN_HEIGHT);
				mul_b = $signed({1'b0, step_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Divider operand selection.
	logic [15:0]   abs_c, abs_s, tnum, tden;
	logic [DW-1:0] div_a, div_b, div_q;
	logic          div_done;

	assign abs_c = c_q[15] ? 16'(-c_q) : 16'(c_q);
	assign abs_s = s_q[15] ? 16'(-s_q) : 16'(s_q);
	assign tnum  = cmd.side ? abs_c : abs_s;
	assign tden  = cmd.side ? abs_s : abs_c;

	always_comb begin
		div_a = '0;
		div_b = '0;
		unique case (cmd.div_sel)
			DIV_TAN: begin
				div_a = {tnum[14:0], {QT{1'b0}}};
				div_b = DW'(tden);
			end
			DIV_RAW: begin
				div_a = DW'(RAW_NUM);
				div_b = dc_q;
			end
			DIV_STEP: begin
				div_a = DW'(STEP_MAX);
				div_b = DW'(raw_q);
			end
			default: begin
				div_a = '0;
				div_b = '0;
			end
		endcase
	end

	grc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	// Saturated signed tangent from the divider quotient.
	logic [19:0]        tan_mag;
	logic signed [20:0] tan_val;

	assign tan_mag = (div_q > DW'(TAN_MAX)) ? 20'(TAN_MAX) : div_q[19:0];
	assign tan_val = (c_q[15] ^ s_q[15]) ? -$signed({1'b0, tan_mag}) : $signed({1'b0, tan_mag});

	// Distance from the two registered products.
	logic signed [PW-1:0] dist_diff;
	logic signed [WW-1:0] dist_new;

	assign dist_diff = acc_q - prod_q;
	assign dist_new  = dist_diff[WW+QT-1:QT];

	// Map registers, written from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				map_q[i] <= '0;
			end
		end else if (cfg_we) begin
			map_q[cfg_row] <= cfg_data;
		end
	end

	// Frame, ray and walk registers.
	always_ff @(posedge clk) begin
		if (cmd.load_frame) begin
			px_q  <= player_x;
			py_q  <= player_y;
			ra_q  <= ra_first;
			ray_q <= '0;
		end
		if (cmd.next_ray) begin
			ray_q <= ray_q + 1'b1;
			ra_q  <= (ra_q == '0) ? 9'd359 : ra_q - 1'b1;
		end
		if (cmd.ray_init) begin
			c_q  <= cos_deg(ra_q);
			s_q  <= sin_deg(ra_q);
			cc_q <= cos_deg(corr_ang);
			dv_q <= WW'(MISS_DIST);
			dh_q <= WW'(MISS_DIST);
			vc_q <= '0;
			hc_q <= '0;
		end
		// First grid line crossing along the chosen axis.
		if (cmd.tan_cap) begin
			t_q <= tan_val;
			if (!cmd.side) begin
				rx_q <= c_q[15] ? basex - WW'(1) : basex + tile_w;
			end else begin
				ry_q <= s_q[15] ? basey + tile_w : basey - WW'(1);
			end
		end
		// Cross coordinate of the first crossing and the step per tile.
		if (cmd.add_cap) begin
			if (!cmd.side) begin
				ry_q <= prod_sh + py_w;
				xs_q <= c_q[15] ? -tile_w : tile_w;
				ys_q <= c_q[15] ? t_ext : -t_ext;
			end else begin
				rx_q <= prod_sh + px_w;
				xs_q <= s_q[15] ? -t_ext : t_ext;
				ys_q <= s_q[15] ? tile_w : -tile_w;
			end
		end
		// One grid step, or record the hit.
		if (cmd.walk_en) begin
			if (in_map && map_cell != '0) begin
				if (!cmd.side) begin
					vc_q   <= map_cell;
					vtex_q <= ry_q[QF+5:QF+1];
				end else begin
					hc_q   <= map_cell;
					htex_q <= rx_q[QF+5:QF+1];
				end
			end else begin
				rx_q <= rx_q + xs_q;
				ry_q <= ry_q + ys_q;
			end
		end
		if (cmd.dist_acc) begin
			acc_q <= prod_q;
		end
		if (cmd.dist_cap) begin
			if (!cmd.side) begin
				dv_q <= dist_new;
			end else begin
				dh_q <= dist_new;
			end
		end
		// Nearer hit wins; a tie goes to the horizontal line.
		if (cmd.pick) begin
			if (dv_q < dh_q) begin
				d_q     <= dv_q;
				code_q  <= vc_q;
				tex_q   <= vtex_q;
				shade_q <= 1'b1;
			end else begin
				d_q     <= dh_q;
				code_q  <= hc_q;
				tex_q   <= htex_q;
				shade_q <= 1'b0;
			end
		end
		// Corrected distance, clamped to one LSB.
		if (cmd.corr_cap) begin
			dc_q <= (prod_sh[WW-1] || prod_sh == '0) ? DW'(1) : prod_sh[DW-1:0];
		end
		if (cmd.raw_cap) begin
			raw_q <= div_q[RAW_W-1:0];
		end
		if (cmd.step_cap) begin
			step_q <= (raw_q == '0) ? 16'(STEP_MAX) : div_q[15:0];
		end
		if (cmd.start_cap) begin
			start_q <= (raw_q > RAW_W'(SCREEN_HEIGHT)) ? prod_q[15:3] : '0;
		end
	end

	// Output column fields.
	logic [8:0] h;
	logic [7:0] top;
	logic       flip;
	logic [4:0] texc;

	assign h    = (raw_q > RAW_W'(SCREEN_HEIGHT)) ? 9'(SCREEN_HEIGHT) : raw_q[8:0];
	assign top  = 8'(SCREEN_HEIGHT / 2) - h[8:1];
	assign flip = shade_q ? (ra_q > 9'd90 && ra_q < 9'd270) : (ra_q > 9'd180);
	assign texc = (code_q == '0) ? 5'd0 : (flip ? ~tex_q : tex_q);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			data_q   <= {7'b0, code_q, step_q, start_q, texc, top, h, ray_q};
			shaded_q <= shade_q;
			last_q   <= (ray_q == RAY_W'(NUM_RAYS - 1));
		end
	end

	assign out_valid  = valid_q;
	assign out_data   = data_q;
	assign out_shaded = shaded_q;
	assign out_last   = last_q;

	// Status to the controller.
	assign sts.c_big    = (c_q > 16'sd16) || (c_q < -16'sd16);
	assign sts.s_big    = (s_q > 16'sd16) || (s_q < -16'sd16);
	assign sts.hit      = in_map && (map_cell != '0);
	assign sts.div_done = div_done;
	assign sts.raw_zero = (raw_q == '0);
	assign sts.out_free = !valid_q || out_ready;
	assign sts.last_ray = (ray_q == RAY_W'(NUM_RAYS - 1));

endmodule

FILE: rtl/grc_ctrl.sv
// Controller: sequences the per-ray steps of a frame over the datapath.
module grc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  grc_pkg::grc_sts_t sts,
	output grc_pkg::grc_cmd_t cmd
);
	import grc_pkg::*;

	typedef enum logic [20:0] {
		ST_IDLE   = 21'd1,
		ST_TRIG   = 21'd2,
		ST_VCHK   = 21'd4,
		ST_HCHK   = 21'd8,
		ST_TDIV   = 21'd16,
		ST_TMUL   = 21'd32,
		ST_TADD   = 21'd64,
		ST_WALK   = 21'd128,
		ST_DIST1  = 21'd256,
		ST_DIST2  = 21'd512,
		ST_DIST3  = 21'd1024,
		ST_PICK   = 21'd2048,
		ST_CORR1  = 21'd4096,
		ST_CORR2  = 21'd8192,
		ST_RAWGO  = 21'd16384,
		ST_RAWW   = 21'd32768,
		ST_STEPGO = 21'd65536,
		ST_STEPW  = 21'd131072,
		ST_START1 = 21'd262144,
		ST_START2 = 21'd524288,
		ST_EMIT   = 21'd1048576
	} state_t;

	state_t           state_q, state_d;
	logic             side_q, side_d;
	logic [CNT_W-1:0] n_q, n_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		side_d  = side_q;
		n_d     = n_q;
		cmd     = '0;
		cmd.div_sel = DIV_TAN;
		cmd.mul_sel = MUL_TAN;
		cmd.side    = side_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_frame = 1'b1;
					state_d = ST_TRIG;
				end
			end
			ST_TRIG: begin
				cmd.ray_init = 1'b1;
				state_d = ST_VCHK;
			end
			ST_VCHK: begin
				side_d   = 1'b0;
				cmd.side = 1'b0;
				if (sts.c_big) begin
					cmd.div_start = 1'b1;
					state_d = ST_TDIV;
				end else begin
					state_d = ST_HCHK;
				end
			end
			ST_HCHK: begin
				side_d   = 1'b1;
				cmd.side = 1'b1;
				if (sts.s_big) begin
					cmd.div_start = 1'b1;
					state_d = ST_TDIV;
				end else begin
					state_d = ST_PICK;
				end
			end
			ST_TDIV: begin
				if (sts.div_done) begin
					cmd.tan_cap = 1'b1;
					state_d = ST_TMUL;
				end
			end
			ST_TMUL: begin
				cmd.mul_sel = MUL_TAN;
				state_d = ST_TADD;
			end
			ST_TADD: begin
				cmd.add_cap = 1'b1;
				n_d = '0;
				state_d = ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_en = 1'b1;
				if (sts.hit) begin
					state_d = ST_DIST1;
				end else if (n_q == CNT_W'(MAX_STEPS - 1)) begin
					state_d = side_q ? ST_PICK : ST_HCHK;
				end else begin
					n_d = n_q + 1'b1;
				end
			end
			ST_DIST1: begin
				cmd.mul_sel = MUL_CDX;
				state_d = ST_DIST2;
			end
			ST_DIST2: begin
				cmd.mul_sel  = MUL_SDY;
				cmd.dist_acc = 1'b1;
				state_d = ST_DIST3;
			end
			ST_DIST3: begin
				cmd.dist_cap = 1'b1;
				state_d = side_q ? ST_PICK : ST_HCHK;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d = ST_CORR1;
			end
			ST_CORR1: begin
				cmd.mul_sel = MUL_CORR;
				state_d = ST_CORR2;
			end
			ST_CORR2: begin
				cmd.corr_cap = 1'b1;
				state_d = ST_RAWGO;
			end
			ST_RAWGO: begin
				cmd.div_sel   = DIV_RAW;
				cmd.div_start = 1'b1;
				state_d = ST_RAWW;
			end
			ST_RAWW: begin
				if (sts.div_done) begin
					cmd.raw_cap = 1'b1;
					state_d = ST_STEPGO;
				end
			end
			ST_STEPGO: begin
				// A zero height takes the maximum step without a division.
				if (sts.raw_zero) begin
					cmd.step_cap = 1'b1;
					state_d = ST_START1;
				end else begin
					cmd.div_sel   = DIV_STEP;
					cmd.div_start = 1'b1;
					state_d = ST_STEPW;
				end
			end
			ST_STEPW: begin
				if (sts.div_done) begin
					cmd.step_cap = 1'b1;
					state_d = ST_START1;
				end
			end
			ST_START1: begin
				cmd.mul_sel = MUL_START;
				state_d = ST_START2;
			end
			ST_START2: begin
				cmd.start_cap = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.last_ray) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_ray = 1'b1;
						state_d = ST_TRIG;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			side_q  <= 1'b0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
			n_q     <= n_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

FILE: rtl/grid_raycast_wall_columns_core.sv
// One frame request yields 60 columns, one per ray.
// The ray time is set by the shared divider, used for up to four divisions per ray,
// and by up to eight map lookups per grid-line walk.
// A new frame request is taken only after the last column has been loaded for output.
// Reset clears the map registers to zero and returns the controller to idle at once.
module grid_raycast_wall_columns_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // player_x[16:0], player_y[33:17], view_angle[42:34]
	output logic        m_tvalid,
	input  logic        m_tready,
	// column[5:0], wall_height[14:6], wall_top[22:15], tex_column[27:23],
	// tex_row_start[40:28], tex_row_step[56:41], tile_code[64:57]
	output logic [71:0] m_tdata,
	output logic        m_tuser,   // shaded[0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import grc_pkg::*;

	grc_cmd_t cmd;
	grc_sts_t sts;

	// Configuration writes are always taken; indexes past the map are dropped.
	assign cfg_ready = 1'b1;

	grc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	grc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.player_x   (s_tdata[16:0]),
		.player_y   (s_tdata[33:17]),
		.view_angle (s_tdata[42:34]),
		.cfg_we     (cfg_valid && (cfg_index < 4'd8)),
		.cfg_row    (cfg_index[2:0]),
		.cfg_data   (cfg_data),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_data   (m_tdata),
		.out_shaded (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

FILE: rtl/grc_checker.sv
// Port-level checker for the wall column core, bound to the top level.
`include "grid_raycast_wall_columns_core_defines.svh"

module grc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	import grc_pkg::*;

	// A stalled column keeps its payload.
	`GRC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tlast, m_tdata}), "stalled column transaction changed")

	// Once a frame request is taken, no other is taken on the next cycle.
	`GRC_ASSERT_NEXT(a_one_frame, s_tvalid && s_tready, !s_tready, "frame request taken twice in a row")

	// The last transaction of a frame carries the last column index.
	`GRC_ASSERT_SAME(a_last_col, m_tvalid && m_tlast, m_tdata[5:0] == 6'(NUM_RAYS - 1), "last flag on a wrong column")

	// Drawn height never exceeds the screen.
	`GRC_ASSERT_SAME(a_height, m_tvalid, m_tdata[14:6] <= 9'(SCREEN_HEIGHT), "wall height above the screen")

endmodule

bind grid_raycast_wall_columns_core grc_checker u_grc_checker (.*);

FILE: sim/grid_raycast_wall_columns_core_monitor.sv
// Checker for the wall column core: predicts every column of a frame and compares the output.
module grid_raycast_wall_columns_core_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import grc_pkg::*;

	localparam longint MISS = longint'(MISS_DIST);

	typedef struct packed {
		logic [5:0]  column;
		logic [8:0]  wall_height;
		logic [7:0]  wall_top;
		logic [4:0]  tex_column;
		logic [12:0] tex_row_start;
		logic [15:0] tex_row_step;
		logic [7:0]  tile_code;
		logic        shaded;
		logic        is_last;
	} wall_column_t;

	logic [63:0]  map_rows [0:7];
	wall_column_t column_queue [$];

	// Table sine of a whole-degree angle, Q2.14.
	function automatic longint sine_q14(input int unsigned a);
		int unsigned b;
		b = a % 360;
		if (b <= 90) return longint'(SIN_TAB[b]);
		if (b <= 180) return longint'(SIN_TAB[180 - b]);
		if (b <= 270) return -longint'(SIN_TAB[b - 180]);
		return -longint'(SIN_TAB[360 - b]);
	endfunction

	function automatic longint cosine_q14(input int unsigned a);
		return sine_q14((a % 360) + 90);
	endfunction

	// Tangent-like ratio in Q.14, truncated and saturated.
	function automatic longint ratio_q14(input longint num, input longint den);
		longint t;
		t = (num * 16384) / den;
		if (t > TAN_MAX) t = TAN_MAX;
		if (t < -TAN_MAX) t = -TAN_MAX;
		return t;
	endfunction

	function automatic logic [7:0] tile_code_at(input longint rx, input longint ry);
		longint mx, my;
		mx = rx >>> POS_SHIFT;
		my = ry >>> POS_SHIFT;
		if (mx < 0 || my < 0 || mx >= MAP_DIM || my >= MAP_DIM || mx >= 8 || my >= 8)
			return 8'd0;
		return map_rows[my][8 * mx +: 8];
	endfunction

	// Steps along one family of grid lines; returns the distance or the miss distance.
	function automatic longint trace_lines(inout longint rx, inout longint ry,
			input longint xo, input longint yo, input longint c, input longint s,
			input longint px, input longint py, output logic [7:0] code);
		logic [7:0] t;
		code = 8'd0;
		for (int n = 0; n < MAX_STEPS; n++) begin
			t = tile_code_at(rx, ry);
			if (t != 8'd0) begin
				code = t;
				return (c * (rx - px) - s * (ry - py)) >>> QT;
			end
			rx += xo;
			ry += yo;
		end
		return MISS;
	endfunction

	// Works out the 60 columns of one frame request.
	task automatic predict_frame(input logic [47:0] req);
		longint px, py, c, s, t, xo, yo, base, vx, vy, hx, hy, dv, dh, d, raw, step, start, h;
		int unsigned pa, ra;
		logic [7:0] vc, hc, code;
		logic [4:0] texc;
		logic shade;
		wall_column_t col;
		px = longint'(req[16:0]);
		py = longint'(req[33:17]);
		pa = int'(req[42:34]) % 360;
		for (int r = 0; r < NUM_RAYS; r++) begin
			ra = (pa + 390 - r) % 360;
			c = cosine_q14(ra);
			s = sine_q14(ra);
			vx = px; vy = py; hx = px; hy = py;
			dv = MISS; dh = MISS;
			vc = 8'd0; hc = 8'd0;
			texc = 5'd0;
			shade = 1'b0;
			// Vertical grid lines.
			if (c > TRIG_EPS || c < -TRIG_EPS) begin
				t = ratio_q14(s, c);
				xo = (c > 0) ? TILE : -TILE;
				base = (px >>> POS_SHIFT) * TILE;
				vx = (c > 0) ? base + TILE : base - 1;
				vy = (((px - vx) * t) >>> QT) + py;
				dv = trace_lines(vx, vy, xo, (-xo * t) >>> QT, c, s, px, py, vc);
			end
			// Horizontal grid lines.
			if (s > TRIG_EPS || s < -TRIG_EPS) begin
				t = ratio_q14(c, s);
				yo = (s > 0) ? -TILE : TILE;
				base = (py >>> POS_SHIFT) * TILE;
				hy = (s > 0) ? base - 1 : base + TILE;
				hx = (((py - hy) * t) >>> QT) + px;
				dh = trace_lines(hx, hy, (-yo * t) >>> QT, yo, c, s, px, py, hc);
			end
			d = dh;
			code = hc;
			if (dv < dh) begin
				d = dv;
				code = vc;
				shade = 1'b1;
			end
			// Fisheye correction, then height and texture scaling.
			d = (d * cosine_q14((pa + 360 - ra) % 360)) >>> QT;
			if (d < 1) d = 1;
			raw = longint'(RAW_NUM) / d;
			step = (raw == 0) ? STEP_MAX : (STEP_MAX / raw);
			if (step > STEP_MAX) step = STEP_MAX;
			start = 0;
			h = raw;
			if (raw > SCREEN_HEIGHT) begin
				start = ((raw - SCREEN_HEIGHT) * step) >>> 3;
				h = SCREEN_HEIGHT;
			end
			if (code != 8'd0) begin
				if (!shade) begin
					texc = hx[13:9];
					if (ra > 180) texc = 5'd31 - texc;
				end else begin
					texc = vy[13:9];
					if (ra > 90 && ra < 270) texc = 5'd31 - texc;
				end
			end
			col.column        = r[5:0];
			col.wall_height   = h[8:0];
			col.wall_top      = 8'(SCREEN_HEIGHT / 2 - (h >>> 1));
			col.tex_column    = texc;
			col.tex_row_start = start[12:0];
			col.tex_row_step  = step[15:0];
			col.tile_code     = code;
			col.shaded        = shade;
			col.is_last       = (r == NUM_RAYS - 1);
			column_queue.push_back(col);
		end
	endtask

	task automatic compare_column(input wall_column_t got);
		wall_column_t exp_col;
		if (column_queue.size() == 0) begin
			$error("column transaction with no column expected");
			fail_count++;
			return;
		end
		exp_col = column_queue.pop_front();
		if (got.column != exp_col.column) begin
			$error("column: expected %0d, got %0d", exp_col.column, got.column);
			fail_count++;
		end
		if (got.wall_height != exp_col.wall_height) begin
			$error("wall_height: expected %0d, got %0d", exp_col.wall_height, got.wall_height);
			fail_count++;
		end
		if (got.wall_top != exp_col.wall_top) begin
			$error("wall_top: expected %0d, got %0d", exp_col.wall_top, got.wall_top);
			fail_count++;
		end
		if (got.tex_column != exp_col.tex_column) begin
			$error("tex_column: expected %0d, got %0d", exp_col.tex_column, got.tex_column);
			fail_count++;
		end
		if (got.tex_row_start != exp_col.tex_row_start) begin
			$error("tex_row_start: expected %0d, got %0d",
				exp_col.tex_row_start, got.tex_row_start);
			fail_count++;
		end
		if (got.tex_row_step != exp_col.tex_row_step) begin
			$error("tex_row_step: expected %0d, got %0d",
				exp_col.tex_row_step, got.tex_row_step);
			fail_count++;
		end
		if (got.tile_code != exp_col.tile_code) begin
			$error("tile_code: expected %0d, got %0d", exp_col.tile_code, got.tile_code);
			fail_count++;
		end
		if (got.shaded != exp_col.shaded) begin
			$error("shaded: expected %0d, got %0d", exp_col.shaded, got.shaded);
			fail_count++;
		end
		if (got.is_last != exp_col.is_last) begin
			$error("is_last: expected %0d, got %0d", exp_col.is_last, got.is_last);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		for (int i = 0; i < 8; i++) map_rows[i] = 64'd0;
	end

	assign pending = column_queue.size();

	// Watch every channel at the rising edge.
	always @(posedge clk) begin
		wall_column_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready && cfg_index < 4'd8) begin
				map_rows[cfg_index[2:0]] = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				predict_frame(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				got.column        = m_tdata[5:0];
				got.wall_height   = m_tdata[14:6];
				got.wall_top      = m_tdata[22:15];
				got.tex_column    = m_tdata[27:23];
				got.tex_row_start = m_tdata[40:28];
				got.tex_row_step  = m_tdata[56:41];
				got.tile_code     = m_tdata[64:57];
				got.shaded        = m_tuser;
				got.is_last       = m_tlast;
				compare_column(got);
			end
		end
	end

endmodule

FILE: sim/grid_raycast_wall_columns_core_test.sv
// Testbench top of the wall column core: clock, reset, map and frame stimulus, verdict.
module grid_raycast_wall_columns_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import grc_pkg::*;

	localparam int MAP_ROW_FIRST = 0;
	localparam int REG_COUNT     = 8;
	localparam int REG_UNUSED    = 9;

	typedef enum int {
		MAP_EMPTY,
		MAP_SOLID,
		MAP_BORDER,
		MAP_NOISE
	} map_kind_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          pending;
	logic        steady;

	grid_raycast_wall_columns_core u_top (.*);

	grid_raycast_wall_columns_core_monitor u_monitor (.*);

	// Clock, and every input known from the start.
	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		steady    = 1'b0;
	end

	always #4 clk = ~clk;

	// Output side back-pressure.
	always @(negedge clk) begin
		m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 13);
	end

	// Run limit.
	initial begin
		#(80_000_000);
		$display("grid_raycast_wall_columns_core_test failed");
		$finish;
	end

	function automatic logic idle_now();
		return !steady && ($urandom_range(99) < 13);
	endfunction

	// One register write transaction; called and left at a falling edge.
	task automatic write_reg(input logic [3:0] idx, input logic [63:0] value);
		while (idle_now()) begin
			cfg_valid <= 1'b0;
			@(negedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// One frame request transaction; called and left at a falling edge.
	task automatic send_frame(input logic [16:0] x, input logic [16:0] y,
			input logic [8:0] angle);
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, angle, y, x};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Waits until every column is in, then a short margin before touching the map.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic load_map(input map_kind_t kind);
		logic [63:0] row;
		for (int i = 0; i < REG_COUNT; i++) begin
			case (kind)
				MAP_EMPTY: row = 64'd0;
				MAP_SOLID: row = '1;
				MAP_BORDER: begin
					for (int j = 0; j < 8; j++) begin
						if (i == 0 || i == 7 || j == 0 || j == 7 || $urandom_range(5) == 0)
							row[8 * j +: 8] = 8'($urandom_range(255, 1));
						else
							row[8 * j +: 8] = 8'd0;
					end
				end
				default: row = {$urandom, $urandom};
			endcase
			write_reg(4'(MAP_ROW_FIRST + i), row);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [8:0] random_angle();
		if ($urandom_range(7) == 0) return 9'($urandom_range(511, 360));
		return 9'($urandom_range(359));
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames on a walled map: corners, axis angles, grid-line origins.
		load_map(MAP_BORDER);
		write_reg(4'(REG_UNUSED), '1);
		cfg_valid <= 1'b0;
		send_frame(17'd0, 17'd0, 9'd0);
		send_frame(17'h1FFFF, 17'h1FFFF, 9'd359);
		send_frame(17'd65536, 17'd65536, 9'd0);
		send_frame(17'd65536, 17'd65536, 9'd90);
		send_frame(17'd65536, 17'd65536, 9'd180);
		send_frame(17'd65536, 17'd65536, 9'd270);
		send_frame(17'd65536, 17'd65536, 9'd45);
		send_frame(17'd16384, 17'd49152, 9'd135);
		send_frame(17'd40000, 17'd90000, 9'd360);
		send_frame(17'd90000, 17'd40000, 9'd511);
		send_frame(17'd20000, 17'd110000, 9'd300);
		send_frame(17'h1FFFF, 17'd0, 9'd225);
		send_frame(17'd0, 17'h1FFFF, 9'd315);
		drain();
		// Nothing to hit, then walls everywhere.
		load_map(MAP_EMPTY);
		send_frame(17'd65536, 17'd65536, 9'd10);
		send_frame(17'd100, 17'd130000, 9'd200);
		drain();
		load_map(MAP_SOLID);
		send_frame(17'd65536, 17'd65536, 9'd30);
		send_frame(17'd130000, 17'd100, 9'd120);
		drain();

		// Random frames over several maps, one phase free of idling.
		for (int phase = 0; phase < 4; phase++) begin
			load_map((phase == 2) ? MAP_NOISE : MAP_BORDER);
			steady = (phase == 1);
			for (int n = 0; n < 36; n++) begin
				send_frame(17'($urandom), 17'($urandom), random_angle());
			end
			drain();
			steady = 1'b0;
		end

		if (fail_count == 0 && pending == 0) begin
			$display("grid_raycast_wall_columns_core_test passed");
		end else begin
			$display("grid_raycast_wall_columns_core_test failed");
		end
		$finish;
	end

endmodule
